// File: hdl/bca_pkg.sv
// Package for the bitmap contiguous block allocator: item types, status codes,
// sequencer states and the small bit helpers used by the allocator top level.
// Depends on nothing.
package bca_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [9:0] block_count;
        logic [8:0] start_block;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] granted_block;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_PREV_RD,
        S_PREV_EV,
        S_ALLOC_WR,
        S_REL_RD,
        S_REL_WR,
        S_DONE
    } state_t;

    // Bits of one map byte that fall in the block range [lo, hi).
    // Block 8*byte+j sits under mask 0x80 >> j.
    function automatic logic [7:0] span_mask(input logic [6:0]  byte_idx,
                                             input logic [9:0]  lo,
                                             input logic [10:0] hi);
        logic [9:0] blk;
        logic [7:0] m;
        m = '0;
        for (int j = 0; j < 8; j++)
        begin
            blk      = {byte_idx, 3'(j)};
            m[7 - j] = (blk >= lo) && ({1'b0, blk} < hi);
        end
        return m;
    endfunction

    // Number of clear low-order bits, 8 for a zero byte.
    function automatic logic [3:0] trailing_zeros(input logic [7:0] b);
        logic [3:0] n;
        logic       hit;
        n   = '0;
        hit = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                hit = 1'b1;
            else if (!hit)
                n = n + 4'd1;
        end
        return n;
    endfunction

endpackage

// File: hdl/bca_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module bca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/bitmap_contiguous_block_allocator.sv
// Top level of the bitmap contiguous block allocator: request sequencer around
// one map RAM. Depends on bca_pkg and bca_ram.
module bitmap_contiguous_block_allocator #(
    parameter int MAP_BYTES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  bca_pkg::req_t req,
    output logic          done,
    output bca_pkg::rsp_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [6:0]    cfg_data
);

    // The free-block map lives in a MAP_BYTES x 8 RAM with a registered read;
    // block b is bit 0x80 >> (b % 8) of byte b / 8. After reset the block
    // writes zeros through every byte of the RAM and holds busy high;
    // configuration writes are still taken then. An item is accepted when
    // start is high while busy is low, and exactly one item is worked on at a
    // time. Its result appears on result for a single cycle with done high;
    // the receiver cannot stall it, so it must take it then. A malformed
    // request goes straight to the done state. An allocation scans the bytes
    // in use one per cycle through the RAM read port, and each byte is judged
    // in the cycle after its read is issued. It then reads the byte before the
    // run and judges it (a run that starts at byte zero skips both), then
    // writes each byte that the granted blocks touch once (no read needed: the
    // run is known to be clear and the byte before it was read already). A
    // release does a read-modify-write of each touched byte. The count of map
    // bytes in use comes from the cfg channel, which is always ready and is
    // meant to be written only while the block is idle; values above
    // MAP_BYTES act as MAP_BYTES.

    localparam int              ADDR_W      = $clog2(MAP_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);
    localparam logic [12:0]     MAP_BYTES_W = 13'(MAP_BYTES);

    bca_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_idx_reg, clr_idx_next;
    logic [6:0]        cfg_reg;
    logic [6:0]        scan_idx_reg, scan_idx_next;
    logic [6:0]        eval_idx_reg, eval_idx_next;
    logic              pend_reg, pend_next;
    logic [7:0]        run_reg, run_next;
    logic [6:0]        run_start_reg, run_start_next;
    logic [7:0]        need_reg, need_next;
    logic [9:0]        count_reg, count_next;
    logic [7:0]        prev_data_reg, prev_data_next;
    logic [9:0]        lo_reg, lo_next;
    logic [10:0]       end_reg, end_next;
    logic [6:0]        cur_reg, cur_next;
    logic [1:0]        status_reg, status_next;
    logic [8:0]        granted_reg, granted_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // Effective number of bytes in use, and the blocks they cover.
    logic [6:0]  eff;
    logic [9:0]  nblk;
    logic [10:0] rel_end;
    logic [10:0] end_m1;
    logic [6:0]  last_byte;
    logic [7:0]  mask;
    logic [6:0]  run_start_sel;
    logic [9:0]  alloc_start;
    logic [7:0]  old_byte;

    assign eff       = ({6'b0, cfg_reg} > MAP_BYTES_W) ? 7'(MAP_BYTES) : cfg_reg;
    assign nblk      = {eff, 3'b000};
    assign rel_end   = {2'b00, req.start_block} + {1'b0, req.block_count};
    assign end_m1    = end_reg - 11'd1;
    assign last_byte = end_m1[9:3];
    assign mask      = bca_pkg::span_mask(cur_reg, lo_reg, end_reg);

    bca_ram #(
        .WIDTH(8),
        .DEPTH(MAP_BYTES)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        scan_idx_next  = scan_idx_reg;
        eval_idx_next  = eval_idx_reg;
        pend_next      = 1'b0;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        need_next      = need_reg;
        count_next     = count_reg;
        prev_data_next = prev_data_reg;
        lo_next        = lo_reg;
        end_next       = end_reg;
        cur_next       = cur_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        ram_we         = 1'b0;
        ram_waddr      = ADDR_W'(cur_reg);
        ram_wdata      = 8'h00;
        ram_re         = 1'b0;
        ram_raddr      = ADDR_W'(scan_idx_reg);
        run_start_sel  = run_start_reg;
        alloc_start    = '0;
        old_byte       = 8'h00;

        case (state_reg)
            bca_pkg::S_CLEAR:
            begin
                // Post-reset sweep: every map byte is written to zero.
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = 8'h00;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_ADDR)
                    state_next = bca_pkg::S_IDLE;
            end

            bca_pkg::S_IDLE:
            begin
                if (start)
                begin
                    count_next    = req.block_count;
                    need_next     = 8'((11'(req.block_count) + 11'd7) >> 3);
                    granted_next  = '0;
                    scan_idx_next = '0;
                    run_next      = '0;
                    run_start_next = '0;
                    if (req.mode == bca_pkg::MODE_ALLOC)
                    begin
                        if (req.block_count == '0 || req.block_count > nblk)
                        begin
                            status_next = bca_pkg::ST_BAD;
                            state_next  = bca_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = bca_pkg::S_SCAN;
                        end
                    end
                    else
                    begin
                        if (req.block_count == '0 || rel_end > {1'b0, nblk})
                        begin
                            status_next = bca_pkg::ST_BAD;
                            state_next  = bca_pkg::S_DONE;
                        end
                        else
                        begin
                            lo_next    = {1'b0, req.start_block};
                            end_next   = rel_end;
                            cur_next   = {1'b0, req.start_block[8:3]};
                            state_next = bca_pkg::S_REL_RD;
                        end
                    end
                end
            end

            bca_pkg::S_SCAN:
            begin
                // Reads run one byte ahead of the evaluation of the last one.
                if (scan_idx_reg < eff)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = ADDR_W'(scan_idx_reg);
                    scan_idx_next = scan_idx_reg + 7'd1;
                    eval_idx_next = scan_idx_reg;
                    pend_next     = 1'b1;
                end
                if (pend_reg)
                begin
                    if (ram_rdata == 8'h00)
                    begin
                        if (run_reg == '0)
                            run_start_sel = eval_idx_reg;
                        run_start_next = run_start_sel;
                        run_next       = run_reg + 8'd1;
                        if (run_reg + 8'd1 == need_reg)
                        begin
                            pend_next  = 1'b0;
                            state_next = bca_pkg::S_PREV_RD;
                        end
                        else if (eval_idx_reg == eff - 7'd1)
                        begin
                            status_next = bca_pkg::ST_NOSPACE;
                            state_next  = bca_pkg::S_DONE;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                        if (eval_idx_reg == eff - 7'd1)
                        begin
                            status_next = bca_pkg::ST_NOSPACE;
                            state_next  = bca_pkg::S_DONE;
                        end
                    end
                end
            end

            bca_pkg::S_PREV_RD:
            begin
                if (run_start_reg == '0)
                begin
                    // Run at the first byte: nothing to step back over.
                    lo_next      = '0;
                    end_next     = {1'b0, count_reg};
                    cur_next     = '0;
                    granted_next = '0;
                    state_next   = bca_pkg::S_ALLOC_WR;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = ADDR_W'(run_start_reg - 7'd1);
                    state_next = bca_pkg::S_PREV_EV;
                end
            end

            bca_pkg::S_PREV_EV:
            begin
                alloc_start    = {run_start_reg, 3'b000}
                                 - {6'b0, bca_pkg::trailing_zeros(ram_rdata)};
                prev_data_next = ram_rdata;
                lo_next        = alloc_start;
                end_next       = {1'b0, alloc_start} + {1'b0, count_reg};
                cur_next       = alloc_start[9:3];
                granted_next   = alloc_start[8:0];
                state_next     = bca_pkg::S_ALLOC_WR;
            end

            bca_pkg::S_ALLOC_WR:
            begin
                // Only the byte before the run can hold set bits.
                if (cur_reg < run_start_reg)
                    old_byte = prev_data_reg;
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(cur_reg);
                ram_wdata = old_byte | mask;
                cur_next  = cur_reg + 7'd1;
                if (cur_reg == last_byte)
                begin
                    status_next = bca_pkg::ST_OK;
                    state_next  = bca_pkg::S_DONE;
                end
            end

            bca_pkg::S_REL_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ADDR_W'(cur_reg);
                state_next = bca_pkg::S_REL_WR;
            end

            bca_pkg::S_REL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(cur_reg);
                ram_wdata = ram_rdata & ~mask;
                cur_next  = cur_reg + 7'd1;
                if (cur_reg == last_byte)
                begin
                    status_next = bca_pkg::ST_OK;
                    state_next  = bca_pkg::S_DONE;
                end
                else
                begin
                    state_next = bca_pkg::S_REL_RD;
                end
            end

            bca_pkg::S_DONE:
            begin
                state_next = bca_pkg::S_IDLE;
            end

            default:
            begin
                state_next = bca_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bca_pkg::S_CLEAR;
            clr_idx_reg <= '0;
            cfg_reg     <= 7'd64;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            pend_reg    <= pend_next;
            if (cfg_valid && cfg_ready)
                cfg_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        eval_idx_reg  <= eval_idx_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        need_reg      <= need_next;
        count_reg     <= count_next;
        prev_data_reg <= prev_data_next;
        lo_reg        <= lo_next;
        end_reg       <= end_next;
        cur_reg       <= cur_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
    end

    assign busy                 = (state_reg != bca_pkg::S_IDLE);
    assign done                 = (state_reg == bca_pkg::S_DONE);
    assign result.status        = status_reg;
    assign result.granted_block = granted_reg;
    assign cfg_ready            = 1'b1;

    // A result strobe lasts exactly one cycle and the block is back to idle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    // An accepted item always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // The map is never read and written at the same entry in one cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("map read and write collide");

    // A result carries a defined status, and a failure grants nothing.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == bca_pkg::ST_OK
                  || ((result.status == bca_pkg::ST_NOSPACE
                       || result.status == bca_pkg::ST_BAD)
                      && result.granted_block == '0)))
        else $error("bad result status or grant");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the bitmap contiguous block allocator.
// Holds its own model of the free-block map and the byte-count register, and checks
// every result against it. Depends on bca_pkg and the allocator top level.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bca_pkg::*;

    localparam int MAP_BYTES = 64;

    // One line of the directed table: either a register write or a request, with
    // an optional hand-written expectation for the request.
    typedef struct {
        bit         is_cfg;
        logic [6:0] cfg;
        req_t       req;
        bit         typed;
        rsp_t       rsp;
    } step_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       done;
    rsp_t       result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    // Model state: the map as the allocator should hold it, and the register.
    logic [7:0] map_model [MAP_BYTES];
    logic [6:0] map_bytes_model;

    // Expected results in order of acceptance, and the runs handed out so far,
    // which the random part uses to build well-formed releases.
    rsp_t       expected_rsp_q [$];
    int         grant_first_q [$];
    int         grant_len_q [$];

    step_t      directed_steps [$];
    int         fail_count = 0;
    int         burst_left = 0;

    bitmap_contiguous_block_allocator #(
        .MAP_BYTES(MAP_BYTES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // Byte count that the register actually selects; values above the map size
    // saturate at the map size.
    function automatic int active_bytes();
        return (int'(map_bytes_model) > MAP_BYTES) ? MAP_BYTES : int'(map_bytes_model);
    endfunction

    // Block b sits in byte b/8 under mask 0x80 >> (b % 8), so bit 7 is the
    // lowest-numbered block of a byte.
    function automatic void mark_block(int blk, logic used);
        int idx;
        idx = blk >> 3;
        if (idx < MAP_BYTES)
            map_model[idx][7 - (blk & 7)] = used;
    endfunction

    // Works out the result of one request and applies its effect on the model map.
    function automatic rsp_t predict_outcome(req_t r);
        rsp_t o;
        int   nbytes;
        int   nblocks;
        int   cnt;
        int   first;
        int   need;
        int   run;
        int   run_start;
        int   base;
        int   k;
        bit   found;
        nbytes          = active_bytes();
        nblocks         = nbytes * 8;
        cnt             = int'(r.block_count);
        first           = int'(r.start_block);
        o.status        = ST_OK;
        o.granted_block = '0;
        if (r.mode == MODE_ALLOC)
        begin
            if (cnt == 0 || cnt > nblocks)
                o.status = ST_BAD;
            else
            begin
                need      = (cnt + 7) / 8;
                run       = 0;
                run_start = 0;
                found     = 1'b0;
                for (int i = 0; i < nbytes && !found; i++)
                begin
                    if (map_model[i] == 8'h00)
                    begin
                        if (run == 0)
                            run_start = i;
                        run++;
                        if (run == need)
                            found = 1'b1;
                    end
                    else
                        run = 0;
                end
                if (!found)
                    o.status = ST_NOSPACE;
                else
                begin
                    // Step back over the free low-order bits of the byte before
                    // the run; a run at byte zero has nothing before it.
                    base = run_start * 8;
                    if (run_start > 0)
                    begin
                        k = 0;
                        while (k < 8 && !map_model[run_start - 1][k])
                        begin
                            base--;
                            k++;
                        end
                    end
                    for (int i = 0; i < cnt; i++)
                        mark_block(base + i, 1'b1);
                    o.granted_block = 9'(base);
                    grant_first_q.push_back(base);
                    grant_len_q.push_back(cnt);
                end
            end
        end
        else
        begin
            if (cnt == 0 || first + cnt > nblocks)
                o.status = ST_BAD;
            else
                for (int i = 0; i < cnt; i++)
                    mark_block(first + i, 1'b0);
        end
        return o;
    endfunction

    function automatic void add_request(logic mode, int cnt, int first, bit typed,
                                        logic [1:0] status, int granted);
        step_t s;
        s.is_cfg              = 1'b0;
        s.cfg                 = '0;
        s.req.mode            = mode;
        s.req.block_count     = 10'(cnt);
        s.req.start_block     = 9'(first);
        s.typed               = typed;
        s.rsp.status          = status;
        s.rsp.granted_block   = 9'(granted);
        directed_steps.push_back(s);
    endfunction

    function automatic void add_cfg(logic [6:0] value);
        step_t s;
        s         = '{default: '0};
        s.is_cfg  = 1'b1;
        s.cfg     = value;
        directed_steps.push_back(s);
    endfunction

    // Random request shaped by the current map size. Most are allocations of
    // modest size and releases of runs granted earlier, so the map keeps a mix
    // of used and free stretches; the rest are random releases, a full clear
    // now and then, and raw noise over every field bit.
    function automatic req_t make_request(int nblocks);
        req_t r;
        int   kind;
        int   pick;
        int   lim;
        r.mode        = MODE_ALLOC;
        r.block_count = '0;
        r.start_block = 9'($urandom);
        kind          = $urandom_range(0, 99);
        if (nblocks == 0 || kind >= 92)
        begin
            r.mode        = 1'($urandom);
            r.block_count = 10'($urandom);
            r.start_block = 9'($urandom);
        end
        else if (kind < 45)
        begin
            lim = (nblocks < 24) ? nblocks : 24;
            if ($urandom_range(0, 4) == 0)
                r.block_count = 10'($urandom_range(1, nblocks));
            else
                r.block_count = 10'($urandom_range(1, lim));
        end
        else if (kind < 80 && grant_first_q.size() > 0)
        begin
            pick          = $urandom_range(0, grant_first_q.size() - 1);
            r.mode        = MODE_RELEASE;
            r.start_block = 9'(grant_first_q[pick]);
            r.block_count = 10'(grant_len_q[pick]);
            grant_first_q.delete(pick);
            grant_len_q.delete(pick);
        end
        else if (kind < 89)
        begin
            r.mode        = MODE_RELEASE;
            r.start_block = 9'($urandom_range(0, nblocks - 1));
            r.block_count = 10'($urandom_range(1, nblocks - int'(r.start_block)));
        end
        else
        begin
            r.mode        = MODE_RELEASE;
            r.start_block = '0;
            r.block_count = 10'(nblocks);
            grant_first_q.delete();
            grant_len_q.delete();
        end
        return r;
    endfunction

    // Offers one item and waits until it is taken. The sender works in bursts:
    // inside a burst items follow back to back, between bursts start is low for
    // a random gap. Start is left high after acceptance; the caller either
    // offers the next item in the same step or lowers it.
    task automatic send_item(req_t r, bit typed, rsp_t typed_rsp);
        int   gap;
        rsp_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 8);
                2: gap = $urandom_range(1, 60);
                default: gap = $urandom_range(60, 200);
            endcase
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        req   <= r;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        // Taken at this edge: the model moves on in the order of acceptance.
        predicted = predict_outcome(r);
        expected_rsp_q.push_back(typed ? typed_rsp : predicted);
    endtask

    // The register is only written once the block has drained every item.
    task automatic write_cfg(logic [6:0] value);
        start <= 1'b0;
        wait (expected_rsp_q.size() == 0);
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        map_bytes_model = value;
        cfg_valid      <= 1'b0;
        burst_left      = 0;
    endtask

    // Each result strobe is matched against the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $error("result with no item outstanding: status %0d, granted_block %0d",
                       result.status, result.granted_block);
                fail_count++;
            end
            else
            begin
                exp_rsp = expected_rsp_q.pop_front();
                if (result.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_rsp.status,
                           result.status);
                    fail_count++;
                end
                if (result.granted_block !== exp_rsp.granted_block)
                begin
                    $error("granted_block: expected %0d, actual %0d",
                           exp_rsp.granted_block, result.granted_block);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        logic [6:0] phase_cfg [9];
        int         phase_items;
        req_t       r;
        rsp_t       none;

        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        none      = '0;
        foreach (map_model[i])
            map_model[i] = 8'h00;
        map_bytes_model = 7'd64;

        // Directed part. With the reset size of 64 bytes: bad counts and ranges,
        // the whole map from byte zero, a full map, the backward step into a
        // partly used byte, release at the last block, and a run too short.
        add_request(MODE_ALLOC,   0,    0,   1, ST_BAD,     0);
        add_request(MODE_ALLOC,   1023, 511, 1, ST_BAD,     0);
        add_request(MODE_ALLOC,   513,  0,   1, ST_BAD,     0);
        add_request(MODE_RELEASE, 0,    5,   1, ST_BAD,     0);
        add_request(MODE_RELEASE, 2,    511, 1, ST_BAD,     0);
        add_request(MODE_ALLOC,   512,  511, 1, ST_OK,      0);
        add_request(MODE_ALLOC,   1,    0,   1, ST_NOSPACE, 0);
        add_request(MODE_RELEASE, 512,  0,   1, ST_OK,      0);
        add_request(MODE_ALLOC,   1,    0,   1, ST_OK,      0);
        add_request(MODE_ALLOC,   8,    0,   0, ST_OK,      0);
        add_request(MODE_ALLOC,   3,    0,   0, ST_OK,      0);
        add_request(MODE_RELEASE, 1,    511, 1, ST_OK,      0);
        add_request(MODE_RELEASE, 5,    2,   0, ST_OK,      0);
        add_request(MODE_ALLOC,   16,   0,   0, ST_OK,      0);
        add_request(MODE_ALLOC,   500,  0,   0, ST_OK,      0);
        add_request(MODE_RELEASE, 512,  0,   1, ST_OK,      0);
        // Smallest useful map: one byte.
        add_cfg(7'd1);
        add_request(MODE_ALLOC,   8,    0,   1, ST_OK,      0);
        add_request(MODE_ALLOC,   1,    0,   1, ST_NOSPACE, 0);
        add_request(MODE_RELEASE, 9,    0,   1, ST_BAD,     0);
        add_request(MODE_RELEASE, 1,    7,   1, ST_OK,      0);
        // No bytes in use: every request is refused.
        add_cfg(7'd0);
        add_request(MODE_ALLOC,   1,    0,   1, ST_BAD,     0);
        add_request(MODE_RELEASE, 1,    0,   1, ST_BAD,     0);
        // Register above the map size saturates at 64 bytes.
        add_cfg(7'd127);
        add_request(MODE_ALLOC,   512,  0,   0, ST_OK,      0);
        add_request(MODE_RELEASE, 512,  0,   1, ST_OK,      0);
        add_request(MODE_ALLOC,   513,  0,   1, ST_BAD,     0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_cfg)
                write_cfg(directed_steps[i].cfg);
            else
                send_item(directed_steps[i].req, directed_steps[i].typed,
                          directed_steps[i].rsp);
        end

        // Random part, in phases of one register setting each.
        phase_cfg = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2,
                      7'($urandom_range(1, 127)), 7'($urandom_range(1, 127)),
                      7'd33, 7'd64};
        foreach (phase_cfg[p])
        begin
            write_cfg(phase_cfg[p]);
            phase_items = (phase_cfg[p] == 7'd0) ? 30 : 110;
            for (int n = 0; n < phase_items; n++)
            begin
                r = make_request(active_bytes() * 8);
                send_item(r, 1'b0, none);
            end
        end

        // Drain, then leave room for any stray strobe before judging.
        start <= 1'b0;
        wait (expected_rsp_q.size() == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && expected_rsp_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
